FILE: hw/rtl/ckpt_pkg.sv
// Package for the cookie keyed pending table.
// Holds the slot entry type, action, status and sequencer codes and defaults.
// No dependencies.
package ckpt_pkg;

  localparam int unsigned SlotsDef = 64;
  localparam logic [15:0] TtlDef   = 16'd10;

  typedef enum logic [2:0] {
    ACT_STORE   = 3'd0,
    ACT_FIND    = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_CLEANUP = 3'd3,
    ACT_TICK    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_WRITE,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic        used;
    logic [31:0] cookie;
    logic [31:0] watch;
    logic [31:0] name;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: hw/rtl/ckpt_cell.sv
// One cell of the rotating slot ring: holds a single table entry.
// Depends on ckpt_pkg for entry_t.
module ckpt_cell
  import ckpt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  logic        used_q;
  logic [31:0] cookie_q, watch_q, name_q, stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= entry_i.used;
    end
  end

  // payload carries no reset: it is ignored while the used bit is low
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      cookie_q <= entry_i.cookie;
      watch_q  <= entry_i.watch;
      name_q   <= entry_i.name;
      stamp_q  <= entry_i.stamp;
    end
  end

  assign entry_o = '{used: used_q, cookie: cookie_q, watch: watch_q,
                     name: name_q, stamp: stamp_q};

endmodule

FILE: hw/rtl/cookie_keyed_pending_table.sv
// Cookie keyed pending table: SLOTS entries held in a ring of cells.
// Find/clear/cleanup rotate the ring once through cell 0; store rotates once to
// choose the slot and once to write it; tick, unknown actions and a zero-cookie
// store skip the ring. One request at a time; a stalled output holds off the next.
// Reset: all slots free, time counter zero, time-to-live 10, outputs idle.
module cookie_keyed_pending_table
  import ckpt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [15:0]        cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [31:0]        cookie_i,
  input  logic signed [31:0] watch_id_i,
  input  logic [31:0]        name_ref_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         slot_index_o,
  output logic signed [31:0] found_watch_id_o,
  output logic [31:0]        found_name_ref_o,
  output logic [6:0]         active_count_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  // ring of cells; cell 0 is the head, data moves toward lower cells
  entry_t cell_out [SLOTS];
  entry_t head_mod;
  logic   shift;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t cin;
    if (k == SLOTS - 1) begin : g_wrap
      assign cin = head_mod;
    end else begin : g_pass
      assign cin = cell_out[k+1];
    end
    ckpt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cin),
      .entry_o (cell_out[k])
    );
  end

  seq_e          state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]    act_q, act_d;
  logic [31:0]   cookie_q, cookie_d, watch_q, watch_d, name_q, name_d;
  logic          hit_q, hit_d, free_q, free_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [IW-1:0] old_idx_q, old_idx_d, tgt_q, tgt_d;
  logic [31:0]   old_stamp_q, old_stamp_d;
  logic [31:0]   fw_q, fw_d, fn_q, fn_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   now_q, now_d;
  logic [15:0]   ttl_q, ttl_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    status_q, status_d;
  logic [5:0]    slot_q, slot_d;
  logic [31:0]   ofw_q, ofw_d, ofn_q, ofn_d;
  logic [6:0]    ocnt_q, ocnt_d;

  entry_t      head;
  logic        match, last, accept;
  logic [31:0] ttl_eff, age, res_slot;

  assign head    = cell_out[0];
  assign match   = head.used && (head.cookie == cookie_q);
  assign last    = (idx_q == LastIdx);
  assign accept  = in_valid_i && (state_q == SEQ_IDLE);
  assign ttl_eff = (ttl_q == 16'd0) ? 32'(TtlDef) : 32'(ttl_q);
  assign age     = now_q - head.stamp;
  assign shift   = (state_q == SEQ_SCAN) || (state_q == SEQ_WRITE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    act_d       = act_q;
    cookie_d    = cookie_q;
    watch_d     = watch_q;
    name_d      = name_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    tgt_d       = tgt_q;
    fw_d        = fw_q;
    fn_d        = fn_q;
    count_d     = count_q;
    now_d       = now_q;
    ttl_d       = cfg_wr_en_i ? cfg_wr_data_i : ttl_q;
    head_mod    = head;
    ovalid_d    = ovalid_q && out_stall_i;
    status_d    = status_q;
    slot_d      = slot_q;
    ofw_d       = ofw_q;
    ofn_d       = ofn_q;
    ocnt_d      = ocnt_q;
    res_slot    = 32'd0;

    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          act_d    = action_i;
          cookie_d = cookie_i;
          watch_d  = watch_id_i;
          name_d   = name_ref_i;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          idx_d    = '0;
          case (action_i)
            ACT_STORE:   state_d = (cookie_i == 32'd0) ? SEQ_DONE : SEQ_SCAN;
            ACT_FIND,
            ACT_CLEAR,
            ACT_CLEANUP: state_d = SEQ_SCAN;
            ACT_TICK: begin
              if (now_q != 32'hFFFF_FFFF) now_d = now_q + 32'd1;
              state_d = SEQ_DONE;
            end
            default:     state_d = SEQ_DONE;
          endcase
        end
      end
      SEQ_SCAN: begin
        case (act_q)
          ACT_STORE: begin
            if (match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
            end
            if (!head.used && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q;
            end
            // strict compare keeps the lowest index on equal stamps
            if (idx_q == '0 || head.stamp < old_stamp_q) begin
              old_idx_d   = idx_q;
              old_stamp_d = head.stamp;
            end
          end
          ACT_FIND: begin
            if (match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
              fw_d      = head.watch;
              fn_d      = head.name;
            end
          end
          ACT_CLEAR: begin
            if (match && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = idx_q;
              head_mod  = '0;
              count_d   = count_q - CW'(1);
            end
          end
          ACT_CLEANUP: begin
            if (head.used && age > ttl_eff) begin
              head_mod = '0;
              count_d  = count_q - CW'(1);
            end
          end
          default: ;
        endcase
        idx_d = last ? '0 : idx_q + IW'(1);
        if (last) begin
          if (act_q == ACT_STORE) begin
            tgt_d   = hit_d ? hit_idx_d : (free_d ? free_idx_d : old_idx_d);
            state_d = SEQ_WRITE;
          end else begin
            state_d = SEQ_DONE;
          end
        end
      end
      SEQ_WRITE: begin
        if (idx_q == tgt_q) begin
          head_mod = '{used: 1'b1, cookie: cookie_q, watch: watch_q,
                       name: name_q, stamp: now_q};
          if (!hit_q && free_q) count_d = count_q + CW'(1);
        end
        idx_d = last ? '0 : idx_q + IW'(1);
        if (last) state_d = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          status_d = ST_DONE;
          ofw_d    = 32'd0;
          ofn_d    = 32'd0;
          case (act_q)
            ACT_STORE: begin
              if (cookie_q == 32'd0) status_d = ST_REJECT;
              else res_slot = 32'(tgt_q);
            end
            ACT_FIND: begin
              if (!hit_q) begin
                status_d = ST_ABSENT;
              end else begin
                res_slot = 32'(hit_idx_q);
                ofw_d    = fw_q;
                ofn_d    = fn_q;
              end
            end
            ACT_CLEAR: begin
              if (!hit_q) status_d = ST_ABSENT;
              else res_slot = 32'(hit_idx_q);
            end
            default: ;
          endcase
          slot_d  = res_slot[5:0];
          ocnt_d  = 7'(count_q);
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      idx_q    <= '0;
      count_q  <= '0;
      now_q    <= 32'd0;
      ttl_q    <= TtlDef;
      ovalid_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      now_q    <= now_d;
      ttl_q    <= ttl_d;
      ovalid_q <= ovalid_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    cookie_q    <= cookie_d;
    watch_q     <= watch_d;
    name_q      <= name_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    tgt_q       <= tgt_d;
    fw_q        <= fw_d;
    fn_q        <= fn_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    ofw_q       <= ofw_d;
    ofn_q       <= ofn_d;
    ocnt_q      <= ocnt_d;
  end

  assign in_stall_o       = (state_q != SEQ_IDLE);
  assign out_valid_o      = ovalid_q;
  assign status_o         = status_q;
  assign slot_index_o     = slot_q;
  assign found_watch_id_o = ofw_q;
  assign found_name_ref_o = ofn_q;
  assign active_count_o   = ocnt_q;

endmodule

FILE: hw/rtl/ckpt_checker.sv
// Port-level checker for the cookie keyed pending table, bound to the top.
// Depends on ckpt_pkg for status codes.
module ckpt_checker
  import ckpt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [5:0]  slot_index_o,
  input logic [31:0] found_watch_id_o,
  input logic [6:0]  active_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DONE || status_o == ST_REJECT ||
                    status_o == ST_ABSENT)
    else $error("bad status code");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |->
      slot_index_o == 6'd0 && found_watch_id_o == 32'd0)
    else $error("failed request carries data");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SLOTS <= 64 |-> 32'(active_count_o) <= SLOTS)
    else $error("active count above slot count");

endmodule

bind cookie_keyed_pending_table ckpt_checker #(.SLOTS(SLOTS)) u_ckpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .slot_index_o     (slot_index_o),
  .found_watch_id_o (found_watch_id_o),
  .active_count_o   (active_count_o)
);
